[hw/rtl/ysch_pkg.sv]
// ----------------------------------------------------------------------------
// ysch_pkg
// Shared types, constants and helpers for the stall compensated heading block.
// ----------------------------------------------------------------------------
package ysch_pkg;

  localparam int unsigned ADDR_W = 4;

  // register index codes (paddr[3:2])
  localparam logic [1:0] IDX_STALL_TOL   = 2'd0;
  localparam logic [1:0] IDX_STALL_WAIT  = 2'd1;
  localparam logic [1:0] IDX_REFRESH_WAIT = 2'd2;

  localparam logic [9:0]  RST_STALL_TOL    = 10'd5;
  localparam logic [15:0] RST_STALL_WAIT   = 16'd500;
  localparam logic [15:0] RST_REFRESH_WAIT = 16'd1000;

  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [15:0] HALF_TURN = 16'd18000;

  // floor(u*1023/36000) = floor(((u*341) >> 5) / 375)
  localparam logic [8:0]  DAC_MUL         = 9'd341;
  localparam int unsigned DAC_PRE_SHIFT   = 5;
  localparam logic [19:0] DAC_RECIP       = 20'd715828;
  localparam int unsigned DAC_RECIP_SHIFT = 28;
  localparam logic [9:0]  DAC_MAX         = 10'd1023;

  typedef struct packed {
    logic [9:0]  stall_tol;
    logic [15:0] stall_wait_ms;
    logic [15:0] refresh_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0] heading;
    logic        stall_fixed;
  } hdg_t;

  // reduce into 0..35999, valid for -108000..107999
  function automatic logic [15:0] mod_turn(input logic signed [18:0] v);
    logic signed [18:0] r;
    if (v < -19'sd72000) begin
      r = v + 19'sd108000;
    end else if (v < -19'sd36000) begin
      r = v + 19'sd72000;
    end else if (v < 19'sd0) begin
      r = v + 19'sd36000;
    end else if (v >= 19'sd72000) begin
      r = v - 19'sd72000;
    end else if (v >= 19'sd36000) begin
      r = v - 19'sd36000;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

endpackage

[hw/rtl/ysch_ifs.sv]
// ----------------------------------------------------------------------------
// ysch_ifs
// Valid/ready channels for yaw samples and heading results.
// ----------------------------------------------------------------------------
interface ysch_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_yaw;
  logic        raw_invalid;
  logic [31:0] now_ms;
  logic        zero_button_n;

  modport source (output valid, raw_yaw, raw_invalid, now_ms, zero_button_n, input ready);
  modport sink (input valid, raw_yaw, raw_invalid, now_ms, zero_button_n, output ready);
endinterface

interface ysch_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading;
  logic [9:0]         dac_level;
  logic               stall_fixed;

  modport source (output valid, heading, dac_level, stall_fixed, input ready);
  modport sink (input valid, heading, dac_level, stall_fixed, output ready);
endinterface

[hw/rtl/ysch_cfg.sv]
// ----------------------------------------------------------------------------
// ysch_cfg
// APB register file for stall tolerance and wait times.
// ----------------------------------------------------------------------------
module ysch_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ysch_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ysch_pkg::cfg_t              cfg
);
  import ysch_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_tol       <= RST_STALL_TOL;
      cfg.stall_wait_ms   <= RST_STALL_WAIT;
      cfg.refresh_wait_ms <= RST_REFRESH_WAIT;
    end else if (wr) begin
      case (paddr[3:2])
        IDX_STALL_TOL:    cfg.stall_tol <= pwdata[9:0];
        IDX_STALL_WAIT:   cfg.stall_wait_ms <= pwdata[15:0];
        IDX_REFRESH_WAIT: cfg.refresh_wait_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      IDX_STALL_TOL:    prdata = {22'd0, cfg.stall_tol};
      IDX_STALL_WAIT:   prdata = {16'd0, cfg.stall_wait_ms};
      IDX_REFRESH_WAIT: prdata = {16'd0, cfg.refresh_wait_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/ysch_core.sv]
// ----------------------------------------------------------------------------
// ysch_core
// Input register, stall detection, offset and zero tracking, heading wrap.
// ----------------------------------------------------------------------------
module ysch_core (
  input  logic           clk,
  input  logic           rst,
  input  ysch_pkg::cfg_t cfg,
  ysch_in_if.sink        in_ch,
  output logic           hdg_valid,
  input  logic           hdg_ready,
  output ysch_pkg::hdg_t hdg
);
  import ysch_pkg::*;

  // input register
  logic        s0_valid;
  logic [15:0] s0_raw;
  logic        s0_invalid;
  logic [31:0] s0_now;
  logic        s0_btn_n;

  // state
  logic [15:0] held_yaw;
  logic [15:0] yaw_offset;
  logic [31:0] last_ok_time;
  logic [15:0] prev_heading;
  logic [15:0] zero_ref;

  logic        s1_free;
  logic        s1_load;
  logic [31:0] elapsed;
  logic [15:0] diff;
  logic        stalled;
  logic        stall_due;
  logic        refresh_due;
  logic        fix;
  logic signed [18:0] off_sum;
  logic [15:0] offset_use;
  logic [15:0] yaw;
  logic signed [18:0] zsum;
  logic signed [18:0] hsum;
  logic [15:0] m;
  logic [15:0] heading_next;

  assign s1_free = !hdg_valid || hdg_ready;
  assign s1_load = s0_valid && s1_free;
  assign in_ch.ready = !s0_valid || s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s0_raw     <= in_ch.raw_yaw;
      s0_invalid <= in_ch.raw_invalid;
      s0_now     <= in_ch.now_ms;
      s0_btn_n   <= in_ch.zero_button_n;
    end
  end

  always_comb begin
    elapsed     = s0_now - last_ok_time;
    diff        = (s0_raw > held_yaw) ? s0_raw - held_yaw : held_yaw - s0_raw;
    stalled     = s0_invalid || (diff <= {6'd0, cfg.stall_tol});
    stall_due   = elapsed > {16'd0, cfg.stall_wait_ms};
    refresh_due = elapsed > {16'd0, cfg.refresh_wait_ms};
    fix         = stalled && stall_due && !s0_invalid;
    off_sum     = signed'({3'b000, yaw_offset}) + signed'({{3{prev_heading[15]}}, prev_heading})
                  - signed'({3'b000, s0_raw});
    offset_use  = fix ? mod_turn(off_sum) : yaw_offset;
    yaw         = s0_invalid ? held_yaw : s0_raw;
    zsum        = signed'({3'b000, yaw}) + signed'({3'b000, offset_use});
    hsum        = zsum - signed'({3'b000, zero_ref});
    m           = !s0_btn_n ? 16'd0 : mod_turn(hsum);
    heading_next = (m > HALF_TURN) ? m - FULL_TURN : m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_yaw     <= 16'd0;
      yaw_offset   <= 16'd0;
      last_ok_time <= 32'd0;
      prev_heading <= 16'd0;
      zero_ref     <= 16'd0;
    end else if (s1_load) begin
      yaw_offset   <= offset_use;
      prev_heading <= heading_next;
      if (fix || (!stalled && refresh_due)) begin
        held_yaw <= s0_raw;
      end
      if (!stalled || stall_due) begin
        last_ok_time <= s0_now;
      end
      if (!s0_btn_n) begin
        zero_ref <= mod_turn(zsum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdg_valid <= 1'b0;
    end else if (s1_free) begin
      hdg_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      hdg.heading     <= heading_next;
      hdg.stall_fixed <= fix;
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_press: assert property (@(posedge clk) disable iff (rst)
    s1_load && !s0_btn_n |=> hdg.heading == 16'd0)
    else $error("zero press did not give a zero heading");

  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    yaw_offset < FULL_TURN && zero_ref < FULL_TURN)
    else $error("offset or zero reference out of turn range");

  a_hdg_range: assert property (@(posedge clk) disable iff (rst)
    hdg_valid |-> $signed(hdg.heading) >= -16'sd17999 && $signed(hdg.heading) <= 16'sd18000)
    else $error("heading out of wrapped range");
`endif

endmodule

[hw/rtl/ysch_dac.sv]
// ----------------------------------------------------------------------------
// ysch_dac
// Two stage scaler from heading to the 10-bit level, with the result register.
// ----------------------------------------------------------------------------
module ysch_dac (
  input  logic           clk,
  input  logic           rst,
  input  logic           hdg_valid,
  output logic           hdg_ready,
  input  ysch_pkg::hdg_t hdg,
  ysch_out_if.source     out_ch
);
  import ysch_pkg::*;

  logic        s2_valid;
  logic [15:0] s2_heading;
  logic        s2_fixed;
  logic [18:0] s2_w;
  logic        s2_free;
  logic        s3_free;
  logic [15:0] u;
  logic [24:0] up;
  logic [38:0] q;

  logic        s3_valid;
  logic [15:0] s3_heading;
  logic [9:0]  s3_dac;
  logic        s3_fixed;

  assign s3_free   = !s3_valid || out_ch.ready;
  assign s2_free   = !s2_valid || s3_free;
  assign hdg_ready = s2_free;

  always_comb begin
    u  = hdg.heading + HALF_TURN;
    up = {9'd0, u} * {16'd0, DAC_MUL};
    q  = {20'd0, s2_w} * {19'd0, DAC_RECIP};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid <= hdg_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdg_valid && s2_free) begin
      s2_heading <= hdg.heading;
      s2_fixed   <= hdg.stall_fixed;
      s2_w       <= up[DAC_PRE_SHIFT +: 19];
    end
    if (s2_valid && s3_free) begin
      s3_heading <= s2_heading;
      s3_fixed   <= s2_fixed;
      s3_dac     <= q[DAC_RECIP_SHIFT +: 10];
    end
  end

  assign out_ch.valid       = s3_valid;
  assign out_ch.heading     = s3_heading;
  assign out_ch.dac_level   = s3_dac;
  assign out_ch.stall_fixed = s3_fixed;

`ifndef NO_ASSERTIONS
  a_dac_top: assert property (@(posedge clk) disable iff (rst)
    s3_valid && s3_heading == HALF_TURN |-> s3_dac == DAC_MAX)
    else $error("level at +180 degrees is not full scale");

  a_dac_bottom: assert property (@(posedge clk) disable iff (rst)
    s3_valid && $signed(s3_heading) == -16'sd17999 |-> s3_dac == 10'd0)
    else $error("level at the lowest heading is not zero");

  a_w_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2_w <= 19'd383625)
    else $error("scaler intermediate out of range");
`endif

endmodule

[hw/rtl/yaw_stall_compensated_heading.sv]
// ----------------------------------------------------------------------------
// yaw_stall_compensated_heading
// Yaw heading with stall compensation, zero reference and analog level output.
// ----------------------------------------------------------------------------
// One yaw sample is taken per clock while the output is not stalled, and each
// gives one result request after the heading, scaler and result registers.
// The per-sample state update (stall timer, held value, offset, zero
// reference, previous heading) closes in a loop through its state registers
// behind the input register, which sets the one-sample-per-cycle rate; the
// level scaling follows in two more register stages. The user must write APB
// registers only while no sample is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module yaw_stall_compensated_heading (
  input  logic                        clk,
  input  logic                        rst,
  ysch_in_if.sink                     in_ch,
  ysch_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ysch_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ysch_pkg::*;

  cfg_t cfg;
  logic hdg_valid;
  logic hdg_ready;
  hdg_t hdg;

  ysch_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ysch_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .hdg_valid (hdg_valid),
    .hdg_ready (hdg_ready),
    .hdg       (hdg)
  );

  ysch_dac u_dac (
    .clk       (clk),
    .rst       (rst),
    .hdg_valid (hdg_valid),
    .hdg_ready (hdg_ready),
    .hdg       (hdg),
    .out_ch    (out_ch)
  );

endmodule
